// File: rtl/stok_pkg.sv
`default_nettype none

package stok_pkg;

    localparam int POS_W      = 16;
    localparam int WORD_DEPTH = 6;

    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    localparam logic [4:0] KIND_LET    = 5'd0;
    localparam logic [4:0] KIND_FN     = 5'd1;
    localparam logic [4:0] KIND_IF     = 5'd2;
    localparam logic [4:0] KIND_ELSE   = 5'd3;
    localparam logic [4:0] KIND_RETURN = 5'd4;
    localparam logic [4:0] KIND_INT    = 5'd5;
    localparam logic [4:0] KIND_FLOAT  = 5'd6;
    localparam logic [4:0] KIND_COLON  = 5'd7;
    localparam logic [4:0] KIND_EQUAL  = 5'd8;
    localparam logic [4:0] KIND_LPAREN = 5'd9;
    localparam logic [4:0] KIND_RPAREN = 5'd10;
    localparam logic [4:0] KIND_LBRACE = 5'd11;
    localparam logic [4:0] KIND_RBRACE = 5'd12;
    localparam logic [4:0] KIND_SEMI   = 5'd13;
    localparam logic [4:0] KIND_PLUS   = 5'd14;
    localparam logic [4:0] KIND_MINUS  = 5'd15;
    localparam logic [4:0] KIND_STAR   = 5'd16;
    localparam logic [4:0] KIND_SLASH  = 5'd17;
    localparam logic [4:0] KIND_IDENT  = 5'd18;
    localparam logic [4:0] KIND_NUMBER = 5'd19;
    localparam logic [4:0] KIND_EOF    = 5'd20;
    localparam logic [4:0] KIND_NONE   = 5'd0;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2,
        MODE_ERROR  = 2'd3
    } t_mode;

    typedef logic [WORD_DEPTH-1:0][7:0] t_word;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } t_in;

    typedef struct packed {
        logic [4:0]       token_kind;
        logic [POS_W-1:0] tok_offset;
        logic [POS_W-1:0] length;
        logic [POS_W-1:0] line_no;
        logic [POS_W-1:0] column_no;
        logic             status;
        logic [7:0]       bad_char;
        logic             last;
    } t_out;

    // up to two result beats written to the output queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_out       beat0;
        t_out       beat1;
    } t_push;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == {POS_W{1'b1}}) ? v : v + POS_W'(1);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // KIND_NONE when c is not punctuation
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            ":":     k = KIND_COLON;
            "=":     k = KIND_EQUAL;
            "(":     k = KIND_LPAREN;
            ")":     k = KIND_RPAREN;
            "{":     k = KIND_LBRACE;
            "}":     k = KIND_RBRACE;
            ";":     k = KIND_SEMI;
            "+":     k = KIND_PLUS;
            "-":     k = KIND_MINUS;
            "*":     k = KIND_STAR;
            "/":     k = KIND_SLASH;
            default: k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] word_kind(input t_word w, input logic [POS_W-1:0] len);
        logic [4:0] k;
        k = KIND_IDENT;
        if (len == POS_W'(3) && w[0] == "l" && w[1] == "e" && w[2] == "t") begin
            k = KIND_LET;
        end else if (len == POS_W'(2) && w[0] == "f" && w[1] == "n") begin
            k = KIND_FN;
        end else if (len == POS_W'(2) && w[0] == "i" && w[1] == "f") begin
            k = KIND_IF;
        end else if (len == POS_W'(4) && w[0] == "e" && w[1] == "l" && w[2] == "s"
                     && w[3] == "e") begin
            k = KIND_ELSE;
        end else if (len == POS_W'(6) && w[0] == "r" && w[1] == "e" && w[2] == "t"
                     && w[3] == "u" && w[4] == "r" && w[5] == "n") begin
            k = KIND_RETURN;
        end else if (len == POS_W'(3) && w[0] == "i" && w[1] == "n" && w[2] == "t") begin
            k = KIND_INT;
        end else if (len == POS_W'(5) && w[0] == "f" && w[1] == "l" && w[2] == "o"
                     && w[3] == "a" && w[4] == "t") begin
            k = KIND_FLOAT;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// File: rtl/stok_outq.sv
`default_nettype none

module stok_outq #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire stok_pkg::t_push i_push,
    output logic               o_room,
    output logic               o_valid,
    input  wire logic          i_ready,
    output stok_pkg::t_out     o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    stok_pkg::t_out r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] w_wr1, w_wr2;
    logic             w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign w_wr1   = ptr_inc(r_wr);
    assign w_wr2   = ptr_inc(w_wr1);
    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_room  = (r_count <= CNT_W'(DEPTH - 2));
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_rd = w_pop ? ptr_inc(r_rd) : r_rd;
        case (i_push.cnt)
            2'd1:    n_wr = w_wr1;
            2'd2:    n_wr = w_wr2;
            default: n_wr = r_wr;
        endcase
        n_count = r_count + CNT_W'(i_push.cnt) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.beat0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[w_wr1] <= i_push.beat1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("output queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> (r_count <= CNT_W'(DEPTH - 2)))
        else $error("push into output queue without room");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("output beat changed while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/source_tokenizer.sv
// Output: a byte's results enter the output queue at its accepting edge.
// Throughput: one byte per cycle while the queue has room for two beats;
//   one result beat leaves per cycle while i_out_ready is high. A byte
//   that closes a token and emits another queues two beats.
// Reset: i_rst_n is synchronous, active low; it clears the scanner to position
//   0, line 1, column 1 and empties the output queue.
`default_nettype none

module source_tokenizer #(
    parameter int OUT_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire stok_pkg::t_in i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output stok_pkg::t_out     o_out_data
);

    localparam int PW = stok_pkg::POS_W;

    stok_pkg::t_mode  r_mode, n_mode;
    stok_pkg::t_word  r_word, n_word;
    logic [PW-1:0]    r_tok_start, n_tok_start;
    logic [PW-1:0]    r_tok_len, n_tok_len;
    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_line, n_line;
    logic [PW-1:0]    r_col, n_col;

    logic             w_accept;
    logic             w_room;
    stok_pkg::t_push  w_push;
    stok_pkg::t_out   w_flush, w_eof, w_single;
    logic [7:0]       w_c;
    logic [PW-1:0]    w_mv_pos, w_mv_line, w_mv_col;
    logic [4:0]       w_pk;
    logic             w_pending, w_extend, w_word_ch;

    assign o_in_ready = w_room;
    assign w_accept   = i_in_valid && w_room;
    assign w_c        = i_in_data.ch;

    always_comb begin
        w_mv_pos  = stok_pkg::sat_inc(r_pos);
        w_mv_line = (w_c == stok_pkg::CH_NEWLINE) ? stok_pkg::sat_inc(r_line) : r_line;
        w_mv_col  = (w_c == stok_pkg::CH_NEWLINE) ? PW'(1) : stok_pkg::sat_inc(r_col);
        w_pk      = stok_pkg::punct_kind(w_c);
        w_word_ch = stok_pkg::is_alpha(w_c) || w_c == stok_pkg::CH_UNDERSCORE;
        w_pending = (r_mode == stok_pkg::MODE_IDENT) || (r_mode == stok_pkg::MODE_NUMBER);
        w_extend  = ((r_mode == stok_pkg::MODE_IDENT) && (w_word_ch || stok_pkg::is_digit(w_c)))
                 || ((r_mode == stok_pkg::MODE_NUMBER)
                     && (stok_pkg::is_digit(w_c) || w_c == stok_pkg::CH_DOT));

        w_flush.token_kind = (r_mode == stok_pkg::MODE_IDENT)
                           ? stok_pkg::word_kind(r_word, r_tok_len) : stok_pkg::KIND_NUMBER;
        w_flush.tok_offset = r_tok_start;
        w_flush.length     = r_tok_len;
        w_flush.line_no    = r_line;
        w_flush.column_no  = r_col;
        w_flush.status     = stok_pkg::STATUS_OK;
        w_flush.bad_char   = 8'd0;
        w_flush.last       = 1'b0;

        w_eof.token_kind = stok_pkg::KIND_EOF;
        w_eof.tok_offset = r_pos;
        w_eof.length     = '0;
        w_eof.line_no    = r_line;
        w_eof.column_no  = r_col;
        w_eof.status     = stok_pkg::STATUS_OK;
        w_eof.bad_char   = 8'd0;
        w_eof.last       = 1'b1;

        // punctuation token, or error beat on an unknown byte
        w_single.tok_offset = r_pos;
        w_single.length     = PW'(1);
        w_single.line_no    = w_mv_line;
        w_single.column_no  = w_mv_col;
        if (w_pk != stok_pkg::KIND_NONE) begin
            w_single.token_kind = w_pk;
            w_single.status     = stok_pkg::STATUS_OK;
            w_single.bad_char   = 8'd0;
            w_single.last       = 1'b0;
        end else begin
            w_single.token_kind = stok_pkg::KIND_NONE;
            w_single.status     = stok_pkg::STATUS_ERROR;
            w_single.bad_char   = w_c;
            w_single.last       = 1'b1;
        end
    end

    always_comb begin
        n_mode      = r_mode;
        n_word      = r_word;
        n_tok_start = r_tok_start;
        n_tok_len   = r_tok_len;
        n_pos       = r_pos;
        n_line      = r_line;
        n_col       = r_col;
        w_push.cnt   = 2'd0;
        w_push.beat0 = w_flush;
        w_push.beat1 = w_eof;

        if (w_accept) begin
            if (i_in_data.end_of_source) begin
                if (r_mode != stok_pkg::MODE_ERROR) begin
                    if (w_pending) begin
                        w_push.cnt = 2'd2;
                    end else begin
                        w_push.cnt   = 2'd1;
                        w_push.beat0 = w_eof;
                    end
                end
                n_mode      = stok_pkg::MODE_IDLE;
                n_word      = '0;
                n_tok_start = '0;
                n_tok_len   = '0;
                n_pos       = '0;
                n_line      = PW'(1);
                n_col       = PW'(1);
            end else if (r_mode == stok_pkg::MODE_ERROR) begin
                n_mode = stok_pkg::MODE_ERROR;
            end else if (w_extend) begin
                for (int i = 0; i < stok_pkg::WORD_DEPTH; i++) begin
                    if (r_tok_len == PW'(i)) begin
                        n_word[i] = w_c;
                    end
                end
                n_tok_len = stok_pkg::sat_inc(r_tok_len);
                n_pos     = w_mv_pos;
                n_line    = w_mv_line;
                n_col     = w_mv_col;
            end else begin
                n_pos  = w_mv_pos;
                n_line = w_mv_line;
                n_col  = w_mv_col;
                n_mode = stok_pkg::MODE_IDLE;
                if (stok_pkg::is_space(w_c)) begin
                    w_push.cnt = w_pending ? 2'd1 : 2'd0;
                end else if (w_word_ch || stok_pkg::is_digit(w_c)) begin
                    w_push.cnt  = w_pending ? 2'd1 : 2'd0;
                    n_mode      = w_word_ch ? stok_pkg::MODE_IDENT : stok_pkg::MODE_NUMBER;
                    n_word      = '0;
                    n_word[0]   = w_c;
                    n_tok_start = r_pos;
                    n_tok_len   = PW'(1);
                end else begin
                    if (w_pending) begin
                        w_push.cnt   = 2'd2;
                        w_push.beat1 = w_single;
                    end else begin
                        w_push.cnt   = 2'd1;
                        w_push.beat0 = w_single;
                    end
                    if (w_pk == stok_pkg::KIND_NONE) begin
                        n_mode = stok_pkg::MODE_ERROR;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= stok_pkg::MODE_IDLE;
            r_word      <= '0;
            r_tok_start <= '0;
            r_tok_len   <= '0;
            r_pos       <= '0;
            r_line      <= PW'(1);
            r_col       <= PW'(1);
        end else begin
            r_mode      <= n_mode;
            r_word      <= n_word;
            r_tok_start <= n_tok_start;
            r_tok_len   <= n_tok_len;
            r_pos       <= n_pos;
            r_line      <= n_line;
            r_col       <= n_col;
        end
    end

    stok_outq #(
        .DEPTH (OUT_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_line_col_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line != '0) && (r_col != '0))
        else $error("line or column counter reached zero");

    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == stok_pkg::MODE_ERROR) |-> (w_push.cnt == 2'd0))
        else $error("result emitted after an unknown character");

    a_pending_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pending |-> (r_tok_len != '0))
        else $error("pending token with zero length");
`endif

endmodule

`default_nettype wire
